// File: design/chm_pkg.sv
// Shared constants, codes and the arctangent table of the compass heading block.
package chm_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int REG_BITS     = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int HEAD_W       = 16;
    localparam int SCALE_SHIFT  = 24;
    localparam int ATAN_FRAC    = 10;
    localparam int ATAN_LEN     = 24;
    localparam int ATAN_W       = 23;
    localparam int ATAN_IW      = $clog2(ATAN_LEN);
    localparam int ZW           = 26;
    localparam int HW           = 18;
    localparam int HSW          = HW + 1;

    localparam int HALF_TURN_CD = 18000;
    localparam int FULL_TURN_CD = 36000;
    localparam int MIN_START    = 10000;
    localparam int MAX_START    = -10000;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLINATION = 2'd3;

    localparam logic signed [ZW-1:0]  HALF_Z     = ZW'(HALF_TURN_CD * (2 ** ATAN_FRAC));
    localparam logic signed [ZW-1:0]  ROUND_HALF = ZW'(2 ** (ATAN_FRAC - 1));
    localparam logic signed [HSW-1:0] TWO_TURN_S = HSW'(2 * FULL_TURN_CD);
    localparam logic [HW-1:0]         TWO_TURN   = HW'(2 * FULL_TURN_CD);
    localparam logic [HW-1:0]         FULL_TURN  = HW'(FULL_TURN_CD);

    // atan(2^-i) in 1/1024 centidegree, rounded
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IW-1:0] idx);
        logic [ATAN_W-1:0] a;
        case (idx)
            5'd0:    a = 23'd4608000;
            5'd1:    a = 23'd2720261;
            5'd2:    a = 23'd1437311;
            5'd3:    a = 23'd729602;
            5'd4:    a = 23'd366217;
            5'd5:    a = 23'd183287;
            5'd6:    a = 23'd91666;
            5'd7:    a = 23'd45836;
            5'd8:    a = 23'd22918;
            5'd9:    a = 23'd11459;
            5'd10:   a = 23'd5730;
            5'd11:   a = 23'd2865;
            5'd12:   a = 23'd1432;
            5'd13:   a = 23'd716;
            5'd14:   a = 23'd358;
            5'd15:   a = 23'd179;
            5'd16:   a = 23'd90;
            5'd17:   a = 23'd45;
            5'd18:   a = 23'd22;
            5'd19:   a = 23'd11;
            5'd20:   a = 23'd6;
            5'd21:   a = 23'd3;
            5'd22:   a = 23'd1;
            5'd23:   a = 23'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: design/chm_if.sv
// Channel interfaces: sample input, result output and register write port.
interface chm_sample_if import chm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mag_x;
    logic signed [SAMPLE_BITS-1:0] mag_y;
    logic signed [SAMPLE_BITS-1:0] mag_z;

    modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
    modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

interface chm_result_if import chm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic [HEAD_W-1:0]             heading;
    logic [SAMPLE_BITS:0]          magnitude_xy;
    logic [SAMPLE_BITS:0]          magnitude_xyz;
    logic signed [SAMPLE_BITS-1:0] min_x;
    logic signed [SAMPLE_BITS-1:0] min_y;
    logic signed [SAMPLE_BITS-1:0] min_z;
    logic signed [SAMPLE_BITS-1:0] max_x;
    logic signed [SAMPLE_BITS-1:0] max_y;
    logic signed [SAMPLE_BITS-1:0] max_z;

    modport source (
        output valid, output heading, output magnitude_xy, output magnitude_xyz,
        output min_x, output min_y, output min_z, output max_x, output max_y, output max_z,
        input ready
    );
    modport sink (
        input valid, input heading, input magnitude_xy, input magnitude_xyz,
        input min_x, input min_y, input min_z, input max_x, input max_y, input max_z,
        output ready
    );
endinterface

interface chm_cfg_if import chm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/chm_sqrt.sv
// Digit-serial integer square root: two radicand bits in, one root bit out per cycle.
module chm_sqrt import chm_pkg::*; #(
    parameter int D_BITS = SAMPLE_BITS_DEF + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2*D_BITS-1:0]   radicand,
    output logic                  busy,
    output logic [D_BITS-1:0]     root
);

    localparam int QW = 2 * D_BITS;
    localparam int RW = D_BITS + 3;
    localparam int NW = $clog2(D_BITS);

    logic [QW-1:0]     rad_reg;
    logic [RW-1:0]     rem_reg;
    logic [D_BITS-1:0] root_reg;
    logic [NW-1:0]     cnt_reg;
    logic              busy_reg;

    logic [RW-1:0]     rem_sh;
    logic [RW:0]       diff;

    assign rem_sh = {rem_reg[RW-3:0], rad_reg[QW-1:QW-2]};
    assign diff   = {1'b0, rem_sh} - {{(RW-D_BITS-1){1'b0}}, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == NW'(D_BITS - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[QW-3:0], 2'b00};
            if (diff[RW])
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[D_BITS-2:0], 1'b0};
            end
            else
            begin
                rem_reg  <= diff[RW-1:0];
                root_reg <= {root_reg[D_BITS-2:0], 1'b1};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// File: design/chm_cordic.sv
// CORDIC vectoring unit: heading from dx, dy plus declination, wrapped to one turn.
module chm_cordic import chm_pkg::*; #(
    parameter int D_BITS = SAMPLE_BITS_DEF + 1,
    parameter int STEPS  = CORDIC_STEPS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [D_BITS-1:0]   dx,
    input  logic signed [D_BITS-1:0]   dy,
    input  logic signed [REG_BITS-1:0] decl,
    output logic                       busy,
    output logic [HEAD_W-1:0]          heading
);

    localparam int CW = D_BITS + SCALE_SHIFT + 2;

    localparam logic [1:0] CS_IDLE  = 2'd0;
    localparam logic [1:0] CS_ITER  = 2'd1;
    localparam logic [1:0] CS_ROUND = 2'd2;
    localparam logic [1:0] CS_WRAP  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [ATAN_IW-1:0]      cnt_reg;
    logic signed [CW-1:0]    x_reg, y_reg;
    logic signed [ZW-1:0]    z_reg;
    logic                    zero_reg;
    logic [HW-1:0]           hsum_reg;
    logic [HEAD_W-1:0]       heading_reg;

    logic signed [CW-1:0]    dx_w, dy_w, xs, ys;
    logic                    y_pos;
    logic signed [ZW-1:0]    at, z_use, z_rnd, z_cd;
    logic signed [HSW-1:0]   zc_s, decl_s, hs;
    logic [HW-1:0]           h1, h2;

    assign dx_w  = {{(CW-D_BITS){dx[D_BITS-1]}}, dx} <<< SCALE_SHIFT;
    assign dy_w  = {{(CW-D_BITS){dy[D_BITS-1]}}, dy} <<< SCALE_SHIFT;
    assign xs    = x_reg >>> cnt_reg;
    assign ys    = y_reg >>> cnt_reg;
    assign y_pos = !y_reg[CW-1] && (y_reg != '0);
    assign at    = {{(ZW-ATAN_W){1'b0}}, atan_entry(cnt_reg)};

    assign z_use  = zero_reg ? '0 : z_reg;
    assign z_rnd  = z_use + ROUND_HALF;
    assign z_cd   = z_rnd >>> ATAN_FRAC;
    assign zc_s   = z_cd[HSW-1:0];
    assign decl_s = {{(HSW-REG_BITS){decl[REG_BITS-1]}}, decl};
    assign hs     = zc_s + decl_s + TWO_TURN_S;

    assign h1 = (hsum_reg >= TWO_TURN) ? hsum_reg - TWO_TURN : hsum_reg;
    assign h2 = (h1 >= FULL_TURN) ? h1 - FULL_TURN : h1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                    state_next = CS_ITER;
            end
            CS_ITER:
            begin
                if (cnt_reg == ATAN_IW'(STEPS - 1))
                    state_next = CS_ROUND;
            end
            CS_ROUND: state_next = CS_WRAP;
            CS_WRAP:  state_next = CS_IDLE;
            default:  state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CS_ITER)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    zero_reg <= (dx == '0) && (dy == '0);
                    // fold the left half-plane onto the right, start at half a turn
                    if (dx[D_BITS-1])
                    begin
                        x_reg <= -dx_w;
                        y_reg <= -dy_w;
                        z_reg <= HALF_Z;
                    end
                    else
                    begin
                        x_reg <= dx_w;
                        y_reg <= dy_w;
                        z_reg <= '0;
                    end
                end
            end
            CS_ITER:
            begin
                if (y_pos)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
            end
            CS_ROUND: hsum_reg <= hs[HW-1:0];
            CS_WRAP:  heading_reg <= h2[HEAD_W-1:0];
            default:  hsum_reg <= hsum_reg;
        endcase
    end

    assign busy    = (state_reg != CS_IDLE);
    assign heading = heading_reg;

endmodule

// File: design/compass_heading_magnitude_top.sv
// Top level: offsets, running extremes, squares, root and CORDIC sequencing, result register.
//
//  channel  dir  beat contents                                         handshake
//  sample   in   mag_x, mag_y, mag_z                                   valid/ready
//  result   out  heading, magnitude_xy/_xyz, min_x.._z, max_x.._z      valid/ready
//  cfg      in   index, data (offset_x/y/z, declination)               valid/ready
//
//  One sample at a time: a new beat is taken only once the CORDIC unit and both roots
//  are free and the result register has taken the last result. The digit-serial roots
//  are DB = max(SAMPLE_BITS, 16) + 1 bits (17 at the defaults), one root bit per cycle.
//  Reset clears offsets and declination to zero, extremes to +10000 / -10000; no clearing pass.
//  The result register holds a beat under stall while the next sample is taken.
module compass_heading_magnitude_top import chm_pkg::*; #(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    chm_sample_if.sink    sample,
    chm_result_if.source  result,
    chm_cfg_if.sink       cfg
);

    localparam int DW = ((SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS) + 1;
    localparam int EW = DW - 1;
    localparam int QW = 2 * DW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam logic [2:0] PH_SQ_X = 3'd0;
    localparam logic [2:0] PH_SQ_Y = 3'd1;
    localparam logic [2:0] PH_SQ_Z = 3'd2;
    localparam logic [2:0] PH_XY   = 3'd3;
    localparam logic [2:0] PH_XYZ  = 3'd4;

    logic [1:0]                 state_reg, state_next;
    logic [2:0]                 ph_reg, ph_next;

    logic signed [REG_BITS-1:0] off_x_reg, off_y_reg, off_z_reg, decl_reg;
    logic signed [DW-1:0]       dx_reg, dy_reg, dz_reg;
    logic signed [EW-1:0]       lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [EW-1:0]       hi_x_reg, hi_y_reg, hi_z_reg;
    logic [QW-1:0]              prod_reg, acc_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [HEAD_W-1:0]          head_out_reg;
    logic [SAMPLE_BITS:0]       mxy_out_reg, mxyz_out_reg;
    logic [SAMPLE_BITS-1:0]     lx_out_reg, ly_out_reg, lz_out_reg;
    logic [SAMPLE_BITS-1:0]     hx_out_reg, hy_out_reg, hz_out_reg;

    logic                       accept, load, any_busy;
    logic signed [DW-1:0]       sx, sy, sz;
    logic signed [DW-1:0]       lx_e, ly_e, lz_e, hx_e, hy_e, hz_e;
    logic signed [DW-1:0]       sq_in;
    logic signed [QW-1:0]       sq_full;

    logic                       cordic_start, cordic_busy;
    logic [HEAD_W-1:0]          cordic_heading;
    logic                       xy_start, xy_busy, xyz_start, xyz_busy;
    logic [DW-1:0]              xy_root, xyz_root;

    assign sx = {{(DW-SAMPLE_BITS){sample.mag_x[SAMPLE_BITS-1]}}, sample.mag_x};
    assign sy = {{(DW-SAMPLE_BITS){sample.mag_y[SAMPLE_BITS-1]}}, sample.mag_y};
    assign sz = {{(DW-SAMPLE_BITS){sample.mag_z[SAMPLE_BITS-1]}}, sample.mag_z};

    assign lx_e = {lo_x_reg[EW-1], lo_x_reg};
    assign ly_e = {lo_y_reg[EW-1], lo_y_reg};
    assign lz_e = {lo_z_reg[EW-1], lo_z_reg};
    assign hx_e = {hi_x_reg[EW-1], hi_x_reg};
    assign hy_e = {hi_y_reg[EW-1], hi_y_reg};
    assign hz_e = {hi_z_reg[EW-1], hi_z_reg};

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign any_busy = cordic_busy || xy_busy || xyz_busy;
    assign load     = (state_reg == ST_WAIT) && !any_busy && (!out_valid_reg || result.ready);

    assign cordic_start = (state_reg == ST_MUL) && (ph_reg == PH_SQ_X);
    assign xy_start     = (state_reg == ST_MUL) && (ph_reg == PH_XY);
    assign xyz_start    = (state_reg == ST_MUL) && (ph_reg == PH_XYZ);

    always_comb
    begin
        case (ph_reg)
            PH_SQ_X: sq_in = dx_reg;
            PH_SQ_Y: sq_in = dy_reg;
            default: sq_in = dz_reg;
        endcase
    end

    assign sq_full = sq_in * sq_in;

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                    ph_next    = PH_SQ_X;
                end
            end
            ST_MUL:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == PH_XYZ)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= PH_SQ_X;
            out_valid_reg <= 1'b0;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            off_z_reg     <= '0;
            decl_reg      <= '0;
            lo_x_reg      <= EW'(MIN_START);
            lo_y_reg      <= EW'(MIN_START);
            lo_z_reg      <= EW'(MIN_START);
            hi_x_reg      <= EW'(MAX_START);
            hi_y_reg      <= EW'(MAX_START);
            hi_z_reg      <= EW'(MAX_START);
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_OFFSET_X:    off_x_reg <= cfg.data;
                    CFG_OFFSET_Y:    off_y_reg <= cfg.data;
                    CFG_OFFSET_Z:    off_z_reg <= cfg.data;
                    CFG_DECLINATION: decl_reg  <= cfg.data;
                    default:         decl_reg  <= decl_reg;
                endcase
            end
            if (accept)
            begin
                if (sx < lx_e) lo_x_reg <= sx[EW-1:0];
                if (sy < ly_e) lo_y_reg <= sy[EW-1:0];
                if (sz < lz_e) lo_z_reg <= sz[EW-1:0];
                if (sx > hx_e) hi_x_reg <= sx[EW-1:0];
                if (sy > hy_e) hi_y_reg <= sy[EW-1:0];
                if (sz > hz_e) hi_z_reg <= sz[EW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg <= sx - {{(DW-REG_BITS){off_x_reg[REG_BITS-1]}}, off_x_reg};
            dy_reg <= sy - {{(DW-REG_BITS){off_y_reg[REG_BITS-1]}}, off_y_reg};
            dz_reg <= sz - {{(DW-REG_BITS){off_z_reg[REG_BITS-1]}}, off_z_reg};
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= sq_full;
            if (ph_reg == PH_SQ_Y)
                acc_reg <= prod_reg;
            else if (ph_reg == PH_SQ_Z || ph_reg == PH_XY)
                acc_reg <= acc_reg + prod_reg;
        end
        if (load)
        begin
            head_out_reg <= cordic_heading;
            mxy_out_reg  <= xy_root[SAMPLE_BITS:0];
            mxyz_out_reg <= xyz_root[SAMPLE_BITS:0];
            lx_out_reg   <= lo_x_reg[SAMPLE_BITS-1:0];
            ly_out_reg   <= lo_y_reg[SAMPLE_BITS-1:0];
            lz_out_reg   <= lo_z_reg[SAMPLE_BITS-1:0];
            hx_out_reg   <= hi_x_reg[SAMPLE_BITS-1:0];
            hy_out_reg   <= hi_y_reg[SAMPLE_BITS-1:0];
            hz_out_reg   <= hi_z_reg[SAMPLE_BITS-1:0];
        end
    end

    chm_cordic #(
        .D_BITS (DW),
        .STEPS  (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .decl    (decl_reg),
        .busy    (cordic_busy),
        .heading (cordic_heading)
    );

    chm_sqrt #(
        .D_BITS (DW)
    ) u_sqrt_xy (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (xy_start),
        .radicand (acc_reg),
        .busy     (xy_busy),
        .root     (xy_root)
    );

    chm_sqrt #(
        .D_BITS (DW)
    ) u_sqrt_xyz (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (xyz_start),
        .radicand (acc_reg),
        .busy     (xyz_busy),
        .root     (xyz_root)
    );

    assign result.valid         = out_valid_reg;
    assign result.heading       = head_out_reg;
    assign result.magnitude_xy  = mxy_out_reg;
    assign result.magnitude_xyz = mxyz_out_reg;
    assign result.min_x         = lx_out_reg;
    assign result.min_y         = ly_out_reg;
    assign result.min_z         = lz_out_reg;
    assign result.max_x         = hx_out_reg;
    assign result.max_y         = hy_out_reg;
    assign result.max_z         = hz_out_reg;

    a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.heading < HEAD_W'(FULL_TURN_CD)))
        else $error("heading beat outside one turn");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.heading)
                                          && $stable(result.magnitude_xyz))
        else $error("result beat changed under stall");

    a_units_free_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !cordic_busy && !xy_busy && !xyz_busy)
        else $error("sample beat taken while an arithmetic unit is busy");

    a_start_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_start |=> (state_reg == ST_MUL) && cordic_busy)
        else $error("CORDIC unit failed to start with the squaring phases");

endmodule
